@@ design/mcs_pkg.sv @@
// Shared types, codes and constants of the cascaded smoother.
`default_nettype none

package mcs_pkg;

    // Fixed field widths
    localparam int ALPHA_W    = 17;
    localparam int FRAC_W     = 16;
    localparam int STAGE_CN_W = 3;
    localparam int ACTIVE_W   = 5;
    localparam int THRESH_W   = 23;
    localparam int ACTION_W   = 2;
    localparam int CHANNEL_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

    // Register reset values
    localparam logic [ALPHA_W-1:0]    ALPHA_RST     = 17'd4096;
    localparam logic [STAGE_CN_W-1:0] STAGE_CN_RST  = 3'd1;
    localparam logic                  ENABLED_RST   = 1'b1;
    localparam logic [ACTIVE_W-1:0]   ACTIVE_RST    = 5'd16;
    localparam logic [THRESH_W-1:0]   THRESHOLD_RST = 23'd256;

    // Item actions
    typedef logic [ACTION_W-1:0] t_action;
    localparam t_action ACT_PROCESS     = 2'd0;
    localparam t_action ACT_RESET_ZERO  = 2'd1;
    localparam t_action ACT_RESET_VALUE = 2'd2;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ALPHA       = 3'd0;
    localparam t_cfg_idx CFG_STAGE_COUNT = 3'd1;
    localparam t_cfg_idx CFG_ENABLED     = 3'd2;
    localparam t_cfg_idx CFG_ACTIVE      = 3'd3;
    localparam t_cfg_idx CFG_THRESHOLD   = 3'd4;

    typedef struct packed {
        logic [ALPHA_W-1:0]    alpha;
        logic [STAGE_CN_W-1:0] stage_count;
        logic                  enabled;
        logic [ACTIVE_W-1:0]   active_channels;
        logic [THRESH_W-1:0]   settle_threshold;
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_MUL  = 5'b00100,
        S_ACC  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

`default_nettype wire

@@ design/mcs_ifs.sv @@
// Handshake interfaces of the smoother: item input, result output, register writes.
`default_nettype none

interface mcs_in_if import mcs_pkg::*; #(parameter int SAMPLE_WIDTH = 24);
    logic                           valid;
    logic                           ready;
    logic [ACTION_W-1:0]            action;
    logic [CHANNEL_W-1:0]           channel;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, action, channel, sample, input ready);
    modport sink   (input valid, action, channel, sample, output ready);
endinterface

interface mcs_out_if #(parameter int SAMPLE_WIDTH = 24);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] value;
    logic                           settled;
    logic                           passed_through;

    modport source (output valid, value, settled, passed_through, input ready);
    modport sink   (input valid, value, settled, passed_through, output ready);
endinterface

interface mcs_cfg_if import mcs_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/multichannel_cascaded_smoother_unit.sv @@
// Top level of the multichannel cascaded one-pole smoother.
//
// Channels: i_cfg takes register writes (index, data), i_in takes items
// (action, channel, sample), o_out returns one result per item (value,
// settled, passed_through). Every channel is a valid/ready transaction.
// Each channel's stage values live in one row of a synchronous RAM, one row
// per channel. A process item reads its row, runs the row through one shared
// stage unit, one stage after another, and writes the row back.
// A smoothed process item passes through a row read (S_READ), then a multiply
// (S_MUL) and a round-and-add (S_ACC) per stage in use in the shared stage
// unit, then S_DONE, where the row is written back as the result enters the
// output register. A channel reset, a bypassed or a no-op item goes straight to S_DONE.
// One item is worked on at a time; the next one can be taken in the same cycle
// in which the result goes valid.
// A finished result waits in the output register; the next item is accepted
// meanwhile. If the receiver still stalls when that item is done, hold it
// until the output register frees up.
// Reset: registers take their defaults and every channel reads as zero
// through one valid flag per row; no clearing pass, no dead time.
`default_nettype none

module multichannel_cascaded_smoother_unit import mcs_pkg::*; #(
    parameter int MAX_STAGE_COUNT = 4,
    parameter int CHANNEL_COUNT   = 16,
    parameter int SAMPLE_WIDTH    = 24
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mcs_cfg_if.sink    i_cfg,
    mcs_in_if.sink     i_in,
    mcs_out_if.source  o_out
);

    localparam int SW       = SAMPLE_WIDTH;
    localparam int ADDR_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int SIDX_W   = (MAX_STAGE_COUNT > 1) ? $clog2(MAX_STAGE_COUNT) : 1;
    localparam int ROW_W    = MAX_STAGE_COUNT * SW;
    localparam int CH_EXT_W = 9;   // holds any channel count up to 256
    localparam int SCNT_W   = 5;   // holds any stage count up to 16
    localparam int CMP_W    = (SW + 1 > THRESH_W) ? SW + 1 : THRESH_W;

    // ---------------- configuration ----------------
    t_cfg w_cfg;

    mcs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // Clamp active channel count and stage count to what the build holds
    logic [CH_EXT_W-1:0] w_act_eff;
    logic [CH_EXT_W-1:0] w_ch_ext;
    logic                w_ch_valid;
    logic [SCNT_W-1:0]   w_sc_raw;
    logic [SCNT_W-1:0]   w_sc_eff;
    logic [SIDX_W-1:0]   w_last_idx;

    assign w_act_eff = (CH_EXT_W'(w_cfg.active_channels) > CH_EXT_W'(CHANNEL_COUNT))
                     ? CH_EXT_W'(CHANNEL_COUNT) : CH_EXT_W'(w_cfg.active_channels);
    assign w_ch_ext   = CH_EXT_W'(i_in.channel);
    assign w_ch_valid = w_ch_ext < w_act_eff;
    assign w_sc_raw   = SCNT_W'(w_cfg.stage_count);
    assign w_sc_eff   = (w_sc_raw == '0) ? SCNT_W'(1)
                      : (w_sc_raw > SCNT_W'(MAX_STAGE_COUNT)) ? SCNT_W'(MAX_STAGE_COUNT)
                      : w_sc_raw;
    assign w_last_idx = SIDX_W'(w_sc_eff - SCNT_W'(1));

    // ---------------- state and registers ----------------
    t_state                  r_state, n_state;
    logic signed [SW-1:0]    r_x, n_x;               // item sample
    logic signed [SW-1:0]    r_stage_x, n_stage_x;   // input of the current stage
    logic signed [SW-1:0]    r_row [MAX_STAGE_COUNT];
    logic signed [SW-1:0]    n_row [MAX_STAGE_COUNT];
    logic [ADDR_W-1:0]       r_addr, n_addr;
    logic [SIDX_W-1:0]       r_stage, n_stage;
    logic [SIDX_W-1:0]       r_last, n_last;
    logic                    r_write, n_write;       // write the row back
    logic signed [SW-1:0]    r_res_value, n_res_value;
    logic                    r_settle_calc, n_settle_calc;
    logic                    r_settled_fix, n_settled_fix;
    logic                    r_res_passed, n_res_passed;
    logic                    r_out_valid, n_out_valid;
    logic signed [SW-1:0]    r_out_value, n_out_value;
    logic                    r_out_settled, n_out_settled;
    logic                    r_out_passed, n_out_passed;
    logic [CHANNEL_COUNT-1:0] r_row_valid, n_row_valid;

    logic w_in_fire;
    logic w_out_free;

    assign i_in.ready = i_rst_n && (r_state == S_IDLE);
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    assign o_out.valid          = r_out_valid;
    assign o_out.value          = r_out_value;
    assign o_out.settled        = r_out_settled;
    assign o_out.passed_through = r_out_passed;

    // ---------------- stage memory ----------------
    logic             w_ram_we;
    logic             w_ram_re;
    logic [ROW_W-1:0] w_ram_wdata;
    logic [ROW_W-1:0] w_ram_rdata;

    assign w_ram_re = w_in_fire;
    assign w_ram_we = (r_state == S_DONE) && w_out_free && r_write;

    for (genvar s = 0; s < MAX_STAGE_COUNT; s++) begin : g_pack
        assign w_ram_wdata[s*SW +: SW] = r_row[s];
    end

    mcs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CHANNEL_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_addr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ch_ext[ADDR_W-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // ---------------- shared stage unit ----------------
    logic                 w_stage_load;
    logic signed [SW-1:0] w_y_new;

    assign w_stage_load = (r_state == S_MUL);

    mcs_stage #(
        .SAMPLE_WIDTH (SW)
    ) u_stage (
        .i_clk   (i_clk),
        .i_load  (w_stage_load),
        .i_x     (r_stage_x),
        .i_y     (r_row[r_stage]),
        .i_alpha (w_cfg.alpha),
        .o_y_new (w_y_new)
    );

    // ---------------- settled flag ----------------
    logic signed [SW:0] w_diff;
    logic [SW:0]        w_mag;
    logic               w_settled_calc;

    assign w_diff         = {r_res_value[SW-1], r_res_value} - {r_x[SW-1], r_x};
    assign w_mag          = w_diff[SW] ? -w_diff : w_diff;
    assign w_settled_calc = CMP_W'(w_mag) < CMP_W'(w_cfg.settle_threshold);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state       = r_state;
        n_x           = r_x;
        n_stage_x     = r_stage_x;
        n_row         = r_row;
        n_addr        = r_addr;
        n_stage       = r_stage;
        n_last        = r_last;
        n_write       = r_write;
        n_res_value   = r_res_value;
        n_settle_calc = r_settle_calc;
        n_settled_fix = r_settled_fix;
        n_res_passed  = r_res_passed;
        n_out_value   = r_out_value;
        n_out_settled = r_out_settled;
        n_out_passed  = r_out_passed;
        n_row_valid   = r_row_valid;
        n_out_valid   = r_out_valid && !o_out.ready;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_x           = i_in.sample;
                    n_stage_x     = i_in.sample;
                    n_addr        = w_ch_ext[ADDR_W-1:0];
                    n_stage       = '0;
                    n_last        = w_last_idx;
                    // defaults: leave the channel alone, echo the sample
                    n_res_value   = i_in.sample;
                    n_settle_calc = 1'b0;
                    n_settled_fix = 1'b0;
                    n_res_passed  = 1'b1;
                    n_write       = 1'b0;
                    n_state       = S_DONE;
                    unique case (i_in.action)
                        ACT_PROCESS: begin
                            n_settle_calc = 1'b1;
                            if (w_cfg.enabled && w_ch_valid) begin
                                n_res_passed = 1'b0;
                                n_write      = 1'b1;
                                n_state      = S_READ;
                            end
                        end
                        ACT_RESET_ZERO, ACT_RESET_VALUE: begin
                            if (w_ch_valid) begin
                                for (int s = 0; s < MAX_STAGE_COUNT; s++) begin
                                    n_row[s] = (i_in.action == ACT_RESET_ZERO)
                                             ? '0 : i_in.sample;
                                end
                                n_res_value   = (i_in.action == ACT_RESET_ZERO)
                                              ? '0 : i_in.sample;
                                n_settled_fix = 1'b1;
                                n_res_passed  = 1'b0;
                                n_write       = 1'b1;
                            end
                        end
                        default: begin
                            // no operation
                            n_write = 1'b0;
                        end
                    endcase
                end
            end
            S_READ: begin
                // a row never written reads as zero
                for (int s = 0; s < MAX_STAGE_COUNT; s++) begin
                    n_row[s] = r_row_valid[r_addr] ? w_ram_rdata[s*SW +: SW] : '0;
                end
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_row[r_stage] = w_y_new;
                n_stage_x      = w_y_new;
                n_res_value    = w_y_new;
                if (r_stage == r_last) begin
                    n_state = S_DONE;
                end else begin
                    n_stage = SIDX_W'(r_stage + 1'b1);
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_value   = r_res_value;
                    n_out_settled = r_settle_calc ? w_settled_calc : r_settled_fix;
                    n_out_passed  = r_res_passed;
                    if (r_write) begin
                        n_row_valid[r_addr] = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_row_valid <= '0;
            r_write     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_row_valid <= n_row_valid;
            r_write     <= n_write;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x           <= n_x;
        r_stage_x     <= n_stage_x;
        r_row         <= n_row;
        r_addr        <= n_addr;
        r_stage       <= n_stage;
        r_last        <= n_last;
        r_res_value   <= n_res_value;
        r_settle_calc <= n_settle_calc;
        r_settled_fix <= n_settled_fix;
        r_res_passed  <= n_res_passed;
        r_out_value   <= n_out_value;
        r_out_settled <= n_out_settled;
        r_out_passed  <= n_out_passed;
    end

    // ---------------- assertions ----------------
    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> !i_in.ready)
        else $error("input accepted while an item is at work");

    a_stage_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_stage <= r_last))
        else $error("stage index ran past the last stage in use");

    a_ram_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ram_we && w_ram_re))
        else $error("row write and row read in the same cycle");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !o_out.ready)
        |=> (r_state == S_DONE && r_out_valid))
        else $error("finished result dropped while output stalled");

endmodule

`default_nettype wire

@@ design/mcs_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module mcs_ram #(
    parameter int  WIDTH = 96,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/mcs_cfg_regs.sv @@
// Configuration register file of the smoother.
`default_nettype none

module mcs_cfg_regs import mcs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mcs_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg               r_cfg;
    logic [ALPHA_W-1:0] w_alpha_raw;

    assign i_cfg.ready = i_rst_n;
    assign w_alpha_raw = i_cfg.data[ALPHA_W-1:0];
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha            <= ALPHA_RST;
            r_cfg.stage_count      <= STAGE_CN_RST;
            r_cfg.enabled          <= ENABLED_RST;
            r_cfg.active_channels  <= ACTIVE_RST;
            r_cfg.settle_threshold <= THRESHOLD_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ALPHA: begin
                    // saturate at one
                    r_cfg.alpha <= (w_alpha_raw > ALPHA_ONE) ? ALPHA_ONE : w_alpha_raw;
                end
                CFG_STAGE_COUNT: begin
                    r_cfg.stage_count <= i_cfg.data[STAGE_CN_W-1:0];
                end
                CFG_ENABLED: begin
                    r_cfg.enabled <= i_cfg.data[0];
                end
                CFG_ACTIVE: begin
                    r_cfg.active_channels <= i_cfg.data[ACTIVE_W-1:0];
                end
                CFG_THRESHOLD: begin
                    r_cfg.settle_threshold <= i_cfg.data[THRESH_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/mcs_stage.sv @@
// One-pole stage datapath: registered alpha*(x - y), then round-half-up and add.
`default_nettype none

module mcs_stage import mcs_pkg::*; #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_load,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_y,
    input  wire logic        [ALPHA_W-1:0]      i_alpha,
    output logic signed      [SAMPLE_WIDTH-1:0] o_y_new
);

    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int PROD_W = DIFF_W + ALPHA_W + 1;
    localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(32768);

    logic signed [DIFF_W-1:0]       w_diff;
    logic signed [ALPHA_W:0]        w_alpha_s;
    logic signed [PROD_W-1:0]       r_prod;
    logic signed [PROD_W-1:0]       w_rounded;
    logic signed [SAMPLE_WIDTH-1:0] r_y;

    assign w_diff    = {i_x[SAMPLE_WIDTH-1], i_x} - {i_y[SAMPLE_WIDTH-1], i_y};
    assign w_alpha_s = {1'b0, i_alpha};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= PROD_W'(w_alpha_s) * PROD_W'(w_diff);
            r_y    <= i_y;
        end
    end

    // floor((p + half) / 2^16); only the low sample bits survive the add
    assign w_rounded = r_prod + HALF_LSB;
    assign o_y_new   = r_y + w_rounded[FRAC_W +: SAMPLE_WIDTH];

endmodule

`default_nettype wire

@@ dv/mcs_smoother_check_pkg.sv @@
// Scoreboard class of the cascaded smoother testbench: predicts each result and checks it.
package mcs_smoother_check_pkg;

    import mcs_pkg::*;

    localparam int SMP_W = 24;
    localparam int N_CH  = 16;
    localparam int N_STG = 4;

    // Action code the block treats as a no-op; not named in the design package
    localparam t_action ACT_NOP = 2'd3;

    typedef logic signed [SMP_W-1:0] t_sample;

    typedef struct {
        t_sample value;
        logic    settled;
        logic    passed;
    } t_result;

    class smoother_scoreboard;
        t_sample               bank [N_CH][N_STG];
        logic [ALPHA_W-1:0]    alpha;
        logic [STAGE_CN_W-1:0] stage_count;
        logic                  enabled;
        logic [ACTIVE_W-1:0]   active_channels;
        logic [THRESH_W-1:0]   threshold;
        t_result               due_q[$];
        int                    errors;

        function new();
            foreach (bank[c, s]) bank[c][s] = '0;
            alpha           = ALPHA_RST;
            stage_count     = STAGE_CN_RST;
            enabled         = ENABLED_RST;
            active_channels = ACTIVE_RST;
            threshold       = THRESHOLD_RST;
            errors          = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ALPHA:       alpha           = data[ALPHA_W-1:0];
                CFG_STAGE_COUNT: stage_count     = data[STAGE_CN_W-1:0];
                CFG_ENABLED:     enabled         = data[0];
                CFG_ACTIVE:      active_channels = data[ACTIVE_W-1:0];
                CFG_THRESHOLD:   threshold       = data[THRESH_W-1:0];
                default: ;
            endcase
        endfunction

        // One pole: y + floor((a*(x - y) + half) / one)
        static function t_sample stage_step(t_sample y, t_sample x, logic [ALPHA_W-1:0] a);
            longint d;
            longint p;
            d = longint'(x) - longint'(y);
            p = longint'(a) * d + 32768;
            return t_sample'(longint'(y) + (p >>> FRAC_W));
        endfunction

        function void note_item(t_action act, logic [CHANNEL_W-1:0] ch, t_sample smp);
            t_result             r;
            logic [ACTIVE_W-1:0] act_lim;
            logic [ALPHA_W-1:0]  a;
            int                  n;
            t_sample             x;
            t_sample             v;
            longint              diff;
            bit                  hit;
            act_lim   = (active_channels > N_CH) ? ACTIVE_W'(N_CH) : active_channels;
            hit       = ch < act_lim;
            r.value   = smp;
            r.settled = 1'b0;
            r.passed  = 1'b1;
            case (act)
                ACT_PROCESS: begin
                    if (enabled && hit) begin
                        a = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
                        n = (stage_count < 1) ? 1 : (stage_count > N_STG) ? N_STG : stage_count;
                        x = smp;
                        for (int s = 0; s < n; s++) begin
                            bank[ch][s] = stage_step(bank[ch][s], x, a);
                            x = bank[ch][s];
                        end
                        r.value  = x;
                        r.passed = 1'b0;
                    end
                    diff = longint'(r.value) - longint'(smp);
                    if (diff < 0) diff = -diff;
                    r.settled = diff < longint'(threshold);
                end
                ACT_RESET_ZERO, ACT_RESET_VALUE: begin
                    if (hit) begin
                        v = (act == ACT_RESET_ZERO) ? t_sample'(0) : smp;
                        for (int s = 0; s < N_STG; s++) bank[ch][s] = v;
                        r.value   = v;
                        r.settled = 1'b1;
                        r.passed  = 1'b0;
                    end
                end
                default: ;
            endcase
            due_q.push_back(r);
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_sample value, logic settled, logic passed);
            t_result r;
            if (due_q.size() == 0) begin
                report($sformatf("result value %0d with no item pending", value));
            end else begin
                r = due_q.pop_front();
                if (value !== r.value)
                    report($sformatf("value %0d, predicted %0d", value, r.value));
                if (settled !== r.settled)
                    report($sformatf("settled %b, predicted %b", settled, r.settled));
                if (passed !== r.passed)
                    report($sformatf("passed_through %b, predicted %b", passed, r.passed));
            end
        endtask
    endclass

endpackage

@@ dv/multichannel_cascaded_smoother_unit_test.sv @@
// Testbench of the multichannel cascaded smoother: directed and random items, scoreboard check.
module multichannel_cascaded_smoother_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mcs_pkg::*;
    import mcs_smoother_check_pkg::*;

    localparam int STALL_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 16;   // allows for the longest item, with margin
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 150;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mcs_in_if  #(.SAMPLE_WIDTH(SMP_W)) in_bus ();
    mcs_out_if #(.SAMPLE_WIDTH(SMP_W)) out_bus ();
    mcs_cfg_if                         cfg_bus ();

    multichannel_cascaded_smoother_unit #(
        .MAX_STAGE_COUNT(N_STG),
        .CHANNEL_COUNT  (N_CH),
        .SAMPLE_WIDTH   (SMP_W)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_bus),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    smoother_scoreboard sb = new();

    // Shared knobs between the stimulus thread and the result-side ready driver
    bit idle_on       = 1'b1;
    bit stall_request = 1'b0;

    // Per-channel target level; random samples wander around it so stages settle
    int level [N_CH];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random back-pressure while idle_on is set, plus one long hold-off on request.
    // The hold-off is counted here so the sender keeps offering items meanwhile.
    initial begin
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_request) begin
                stall_request = 1'b0;
                out_bus.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
            end else begin
                out_bus.ready <= idle_on ? ($urandom_range(99) >= 35) : 1'b1;
            end
        end
    end

    // Check every result transaction against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready)
            sb.check_result(out_bus.value, out_bus.settled, out_bus.passed_through);
    end

    // Offer one item and hold it until the block takes the transaction.
    // Valid stays high on return so back-to-back items need no dead cycle.
    task automatic send_item(t_action act, logic [CHANNEL_W-1:0] ch, t_sample smp);
        while (idle_on && $urandom_range(99) < 35) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.action  <= act;
        in_bus.channel <= ch;
        in_bus.sample  <= smp;
        do @(posedge i_clk); while (!in_bus.ready);
        sb.note_item(act, ch, smp);
    endtask

    // Drop valid and wait until every predicted result has been checked
    task automatic drain();
        in_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        sb.write_reg(idx, data);
    endtask

    // Write all five registers; only called with the block idle
    task automatic apply_settings(logic [ALPHA_W-1:0] a, logic [STAGE_CN_W-1:0] sc,
                                  logic en, logic [ACTIVE_W-1:0] ac,
                                  logic [THRESH_W-1:0] th);
        write_reg(CFG_ALPHA, CFG_DATA_W'(a));
        write_reg(CFG_STAGE_COUNT, CFG_DATA_W'(sc));
        write_reg(CFG_ENABLED, CFG_DATA_W'(en));
        write_reg(CFG_ACTIVE, CFG_DATA_W'(ac));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(th));
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic t_sample clamp_sample(int v);
        if (v > 8388607) return t_sample'(8388607);
        if (v < -8388608) return t_sample'(-8388608);
        return t_sample'(v);
    endfunction

    localparam t_sample SMP_MAX = 24'sh7FFFFF;
    localparam t_sample SMP_MIN = 24'sh800000;

    initial begin
        logic [ALPHA_W-1:0]    a;
        logic [STAGE_CN_W-1:0] sc;
        logic                  en;
        logic [ACTIVE_W-1:0]   ac;
        logic [THRESH_W-1:0]   th;
        t_action               act;
        logic [CHANNEL_W-1:0]  ch;
        t_sample               smp;
        int                    roll;

        foreach (level[c]) level[c] = 0;

        // Hold every input at a known value through reset
        i_rst_n         <= 1'b0;
        in_bus.valid    <= 1'b0;
        in_bus.action   <= ACT_PROCESS;
        in_bus.channel  <= '0;
        in_bus.sample   <= '0;
        cfg_bus.valid   <= 1'b0;
        cfg_bus.index   <= CFG_ALPHA;
        cfg_bus.data    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset defaults, sample extremes, resets and the no-op action
        send_item(ACT_PROCESS, 4'd0, SMP_MAX);
        send_item(ACT_PROCESS, 4'd0, SMP_MIN);
        send_item(ACT_PROCESS, 4'd15, t_sample'(0));
        send_item(ACT_PROCESS, 4'd7, t_sample'(-1));
        send_item(ACT_RESET_VALUE, 4'd3, SMP_MAX);
        send_item(ACT_PROCESS, 4'd3, SMP_MIN);
        send_item(ACT_RESET_ZERO, 4'd3, SMP_MAX);
        send_item(ACT_NOP, 4'd9, t_sample'(12345));
        drain();

        // Unity alpha, full cascade, five active channels, zero threshold
        apply_settings(ALPHA_ONE, 3'd4, 1'b1, 5'd5, 23'd0);
        send_item(ACT_RESET_VALUE, 4'd2, t_sample'(-4000));
        send_item(ACT_PROCESS, 4'd2, SMP_MAX);
        send_item(ACT_PROCESS, 4'd4, SMP_MIN);
        send_item(ACT_PROCESS, 4'd5, t_sample'(77));       // inactive: bypass
        send_item(ACT_RESET_VALUE, 4'd9, t_sample'(555));  // inactive: ignored
        send_item(ACT_RESET_ZERO, 4'd12, t_sample'(1));
        drain();

        // Oversized alpha, stage count zero, disabled, oversized active count, max threshold
        apply_settings(17'h1FFFF, 3'd0, 1'b0, 5'd31, 23'h7FFFFF);
        send_item(ACT_PROCESS, 4'd1, SMP_MIN);
        send_item(ACT_RESET_VALUE, 4'd1, SMP_MIN);         // resets ignore enabled
        send_item(ACT_PROCESS, 4'd15, SMP_MAX);
        send_item(ACT_NOP, 4'd15, SMP_MIN);
        drain();

        // Zero alpha, stage count above maximum, no channels active
        apply_settings(17'd0, 3'd7, 1'b1, 5'd0, 23'd1);
        send_item(ACT_PROCESS, 4'd0, t_sample'(100));
        send_item(ACT_RESET_ZERO, 4'd0, t_sample'(100));
        drain();

        apply_settings(17'd0, 3'd7, 1'b1, 5'd16, 23'd1);
        send_item(ACT_PROCESS, 4'd2, SMP_MAX);
        send_item(ACT_PROCESS, 4'd4, SMP_MAX);
        drain();

        // Random phases, each with its own settings
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case ($urandom_range(4))
                0:       a = ALPHA_ONE;
                1:       a = ALPHA_W'($urandom_range(131071));
                2:       a = ALPHA_W'($urandom_range(1, 2048));
                default: a = ALPHA_W'($urandom_range(65536));
            endcase
            sc = ($urandom_range(3) == 0) ? STAGE_CN_W'($urandom_range(7))
                                          : STAGE_CN_W'($urandom_range(1, 4));
            en = $urandom_range(9) != 0;
            ac = ($urandom_range(3) == 0) ? ACTIVE_W'($urandom_range(31)) : ACTIVE_W'(16);
            case ($urandom_range(3))
                0:       th = '0;
                1:       th = THRESH_W'($urandom_range(1, 64));
                2:       th = THRESH_W'($urandom_range(65536));
                default: th = 23'h7FFFFF;
            endcase
            apply_settings(a, sc, en, ac, th);

            idle_on = (p != 3);           // one long stretch with no idling on either side
            if (p == 2) stall_request = 1'b1;

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 5 && i == PHASE_ITEMS / 2) drain();

                roll = $urandom_range(99);
                act  = (roll < 84) ? ACT_PROCESS :
                       (roll < 91) ? ACT_RESET_ZERO :
                       (roll < 98) ? ACT_RESET_VALUE : ACT_NOP;
                ch   = CHANNEL_W'($urandom_range(N_CH - 1));

                // Move the channel's target now and then, sometimes to an extreme
                roll = $urandom_range(99);
                if (roll < 3)
                    level[ch] = int'(SMP_MAX);
                else if (roll < 6)
                    level[ch] = int'(SMP_MIN);
                else if (roll < 14)
                    level[ch] = int'(t_sample'($urandom));

                if ($urandom_range(9) == 0)
                    smp = t_sample'($urandom);
                else
                    smp = clamp_sample(level[ch] + int'($urandom_range(64)) - 32);
                send_item(act, ch, smp);
            end
        end

        // Let the last results arrive, then allow the longest item time to pass
        drain();
        idle_on = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d predicted results never arrived", sb.pending()));

        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/mcs_pkg.sv
design/mcs_ifs.sv
design/mcs_ram.sv
design/mcs_cfg_regs.sv
design/mcs_stage.sv
design/multichannel_cascaded_smoother_unit.sv
dv/mcs_smoother_check_pkg.sv
dv/multichannel_cascaded_smoother_unit_test.sv
